@@ src/bpfa_pkg.sv @@
// bpfa_pkg: constants, command/status/operation codes of the bitmap page allocator
// no dependencies; used by bpfa_if, bpfa_front, bpfa_back, the top level and tb
`default_nettype none
package bpfa_pkg;
	localparam int MAX_PAGES   = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 48;
	localparam int CNT_W       = 13;
	localparam int CMD_W       = 2;
	localparam int ST_W        = 2;
	localparam int WORD_BITS   = 64;
	localparam int RESET_PAGES = 4096;
	localparam int CFG_IDX_W   = 1;
	localparam int OP_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET_MAP = 2'd0,
		CMD_ALLOC     = 2'd1,
		CMD_FREE      = 2'd2,
		CMD_MARK_USED = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FAIL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// classified request as it travels through the queue
	typedef enum logic [OP_W-1:0] {
		OP_RESET = 3'd0,
		OP_ALLOC = 3'd1,
		OP_FREE  = 3'd2,
		OP_MARK  = 3'd3,
		OP_FAIL  = 3'd4,
		OP_RANGE = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 1'd0,
		REG_PAGE_TOTAL   = 1'd1
	} reg_t;
endpackage
`default_nettype wire

@@ src/bpfa_if.sv @@
// bpfa channel interfaces: request, response and configuration write
// depends on bpfa_pkg for field widths
`default_nettype none
interface bpfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::CMD_W-1:0]    cmd;
	logic [bpfa_pkg::ADDR_W-1:0]   address;
	logic [bpfa_pkg::CNT_W-1:0]    count;
	modport source (output valid, cmd, address, count, input ready);
	modport sink (input valid, cmd, address, count, output ready);
endinterface

interface bpfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::ST_W-1:0]     status;
	logic [bpfa_pkg::ADDR_W-1:0]   page_address;
	logic [bpfa_pkg::CNT_W-1:0]    free_count;
	modport source (output valid, status, page_address, free_count, input ready);
	modport sink (input valid, status, page_address, free_count, output ready);
endinterface

interface bpfa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bpfa_pkg::CFG_IDX_W-1:0]  index;
	logic [bpfa_pkg::ADDR_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/bpfa_ram.sv @@
// bpfa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module bpfa_ram #(
	parameter int Width = 64,
	parameter int Depth = 64,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ src/bpfa_queue.sv @@
// bpfa_queue: two-entry request queue between front and back
// no dependencies
`default_nettype none
module bpfa_queue #(
	parameter int Width = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] push_data,
	input  wire logic             pop,
	output logic      [Width-1:0] pop_data,
	output logic                  full,
	output logic                  empty
);
	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);

	logic [Width-1:0]  mem_q [Depth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [PtrW:0]     fill_q;

	assign full     = (fill_q == (PtrW + 1)'(Depth));
	assign empty    = (fill_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/bpfa_front.sv @@
// bpfa_front: accepts requests, range-checks addresses and counts, classifies
// depends on bpfa_pkg and bpfa_if
`default_nettype none
module bpfa_front #(
	parameter int MaxPages  = bpfa_pkg::MAX_PAGES,
	parameter int PageShift = bpfa_pkg::PAGE_SHIFT,
	parameter int IdxW      = $clog2(MaxPages),
	parameter int TotW      = $clog2(MaxPages + 1),
	parameter int QW        = bpfa_pkg::OP_W + IdxW + TotW
) (
	bpfa_req_if.sink                        req,
	input  wire logic [bpfa_pkg::ADDR_W-1:0] abase,
	input  wire logic [TotW-1:0]            total,
	input  wire logic                       en,
	input  wire logic                       q_full,
	output logic                            push,
	output logic      [QW-1:0]              push_data
);
	localparam int PidxW = bpfa_pkg::ADDR_W - PageShift;

	logic [bpfa_pkg::ADDR_W:0] diff;
	logic [PidxW-1:0]          pidx;
	logic                      in_range;
	logic                      bad_count;
	bpfa_pkg::op_t             op;

	assign diff      = {1'b0, req.address} - {1'b0, abase};
	assign pidx      = diff[bpfa_pkg::ADDR_W-1:PageShift];
	assign in_range  = !diff[bpfa_pkg::ADDR_W] && (pidx < PidxW'(total));
	assign bad_count = (req.count == '0) || (32'(req.count) > 32'(total));

	assign req.ready = en && !q_full;
	assign push      = req.valid && req.ready;

	always_comb begin
		case (bpfa_pkg::cmd_t'(req.cmd))
			bpfa_pkg::CMD_RESET_MAP: op = bpfa_pkg::OP_RESET;
			bpfa_pkg::CMD_ALLOC:     op = bad_count ? bpfa_pkg::OP_FAIL : bpfa_pkg::OP_ALLOC;
			bpfa_pkg::CMD_FREE:      op = in_range ? bpfa_pkg::OP_FREE : bpfa_pkg::OP_RANGE;
			bpfa_pkg::CMD_MARK_USED: op = in_range ? bpfa_pkg::OP_MARK : bpfa_pkg::OP_RANGE;
			default:                 op = bpfa_pkg::OP_RANGE;
		endcase
	end

	// count is only used when it passed the check, so it fits the total width
	assign push_data = {op, IdxW'(pidx), TotW'(req.count)};
endmodule
`default_nettype wire

@@ src/bpfa_back.sv @@
// bpfa_back: executes queued requests on the free map ram, holds free counter
// and the response register; depends on bpfa_pkg, bpfa_if and bpfa_ram
`default_nettype none
module bpfa_back #(
	parameter int MaxPages  = bpfa_pkg::MAX_PAGES,
	parameter int PageShift = bpfa_pkg::PAGE_SHIFT,
	parameter int IdxW      = $clog2(MaxPages),
	parameter int TotW      = $clog2(MaxPages + 1),
	parameter int QW        = bpfa_pkg::OP_W + IdxW + TotW
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [bpfa_pkg::ADDR_W-1:0] abase,
	input  wire logic [TotW-1:0]             total,
	input  wire logic                        q_empty,
	input  wire logic [QW-1:0]               q_data,
	output logic                             q_pop,
	output logic                             ready,
	bpfa_rsp_if.source                       rsp
);
	localparam int WB       = bpfa_pkg::WORD_BITS;
	localparam int BitW     = $clog2(WB);
	localparam int MapWords = (MaxPages + WB - 1) / WB;
	localparam int AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
	localparam int PW       = $clog2(MapWords + 1);
	localparam int RunW     = TotW + 1;
	localparam int CW       = bpfa_pkg::CNT_W;
	localparam int RstFree  = (MaxPages < bpfa_pkg::RESET_PAGES) ? MaxPages
	                                                              : bpfa_pkg::RESET_PAGES;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_MARK_RD, S_MARK_WR,
		S_BIT_RD, S_BIT_WR, S_RESP
	} state_t;

	state_t                       state_q;
	logic                         init_q;
	logic [PW-1:0]                wptr_q;
	bpfa_pkg::op_t                op_q;
	logic [IdxW-1:0]              idx_q;
	logic [TotW-1:0]              cnt_q;
	logic [RunW-1:0]              run_q;
	logic [IdxW-1:0]              start_q;
	logic [IdxW-1:0]              end_q;
	logic [CW-1:0]                free_q;
	bpfa_pkg::status_t            st_q;
	logic [bpfa_pkg::ADDR_W-1:0]  res_addr_q;
	logic                         out_v_q;
	logic [bpfa_pkg::ST_W-1:0]    out_st_q;
	logic [bpfa_pkg::ADDR_W-1:0]  out_addr_q;
	logic [CW-1:0]                out_free_q;

	logic                         we;
	logic [WB-1:0]                wdata;
	logic [WB-1:0]                rdata;
	logic [WB-1:0]                scan_w;
	logic [RunW-1:0]              run_a [WB];
	logic [WB-1:0]                hit_v;
	logic [BitW-1:0]              first_j;
	logic [IdxW-1:0]              start_c;
	logic [WB-1:0]                mmask;
	logic [WB-1:0]                bitm;
	logic                         bit_free;
	logic                         last_word;
	logic                         past_total;
	logic                         zf;
	int                           zpos;

	bpfa_ram #(.Width(WB), .Depth(MapWords)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(wptr_q)),
		.wdata (wdata),
		.raddr (AW'(wptr_q)),
		.rdata (rdata)
	);

	assign ready      = !init_q;
	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign past_total = (32'(wptr_q) * WB) >= 32'(total);
	assign bitm       = WB'(1) << idx_q[BitW-1:0];
	assign bit_free   = (rdata & bitm) != '0;
	assign last_word  = (32'(end_q) >> BitW) == 32'(wptr_q);

	// run of free pages ending at each bit, carried in from earlier words
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			scan_w[j] = rdata[j] && ((32'(wptr_q) * WB + j) < 32'(total));
		end
		for (int j = 0; j < WB; j++) begin
			zf   = 1'b0;
			zpos = 0;
			for (int k = 0; k < WB; k++) begin
				if (k <= j && !scan_w[k]) begin
					zf   = 1'b1;
					zpos = k;
				end
			end
			run_a[j] = zf ? RunW'(j - zpos) : run_q + RunW'(j + 1);
			hit_v[j] = run_a[j] >= RunW'(cnt_q);
		end
		first_j = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (hit_v[j]) begin
				first_j = BitW'(j);
			end
		end
		start_c = IdxW'(32'(wptr_q) * WB + 32'(first_j) + 1 - 32'(cnt_q));
	end

	// pages of the allocated run that fall in the current word
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			mmask[j] = ((32'(wptr_q) * WB + j) >= 32'(start_q))
			        && ((32'(wptr_q) * WB + j) <= 32'(end_q));
		end
	end

	always_comb begin
		we    = 1'b0;
		wdata = rdata;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				wdata = '1;
			end
			S_MARK_WR: begin
				we    = 1'b1;
				wdata = rdata & ~mmask;
			end
			S_BIT_WR: begin
				we    = 1'b1;
				wdata = (op_q == bpfa_pkg::OP_FREE) ? (rdata | bitm) : (rdata & ~bitm);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			init_q     <= 1'b1;
			wptr_q     <= '0;
			free_q     <= CW'(RstFree);
			out_v_q    <= 1'b0;
			op_q       <= bpfa_pkg::OP_RESET;
			st_q       <= bpfa_pkg::ST_DONE;
		end else begin
			// response register loads in S_RESP, else empties when taken
			if (state_q == S_RESP && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (32'(wptr_q) == MapWords - 1) begin
						init_q <= 1'b0;
						if (!init_q) begin
							free_q  <= CW'(total);
							state_q <= S_RESP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						op_q       <= bpfa_pkg::op_t'(q_data[QW-1 -: bpfa_pkg::OP_W]);
						idx_q      <= q_data[TotW +: IdxW];
						cnt_q      <= q_data[TotW-1:0];
						st_q       <= bpfa_pkg::ST_DONE;
						res_addr_q <= '0;
						run_q      <= '0;
						case (bpfa_pkg::op_t'(q_data[QW-1 -: bpfa_pkg::OP_W]))
							bpfa_pkg::OP_RESET: begin
								wptr_q  <= '0;
								state_q <= S_CLEAR;
							end
							bpfa_pkg::OP_ALLOC: begin
								wptr_q  <= '0;
								state_q <= S_SCAN_RD;
							end
							bpfa_pkg::OP_FREE, bpfa_pkg::OP_MARK: begin
								wptr_q  <= PW'(32'(q_data[TotW +: IdxW]) >> BitW);
								state_q <= S_BIT_RD;
							end
							bpfa_pkg::OP_FAIL: begin
								st_q    <= bpfa_pkg::ST_FAIL;
								state_q <= S_RESP;
							end
							default: begin
								st_q    <= bpfa_pkg::ST_RANGE;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					if (past_total) begin
						st_q    <= bpfa_pkg::ST_FAIL;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					if (hit_v != '0) begin
						start_q <= start_c;
						end_q   <= start_c + IdxW'(cnt_q - 1'b1);
						wptr_q  <= PW'(32'(start_c) >> BitW);
						state_q <= S_MARK_RD;
					end else begin
						run_q   <= run_a[WB-1];
						wptr_q  <= wptr_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (last_word) begin
						free_q     <= (32'(free_q) > 32'(cnt_q)) ? free_q - CW'(cnt_q) : '0;
						res_addr_q <= abase + (bpfa_pkg::ADDR_W'(start_q) << PageShift);
						state_q    <= S_RESP;
					end else begin
						wptr_q  <= wptr_q + 1'b1;
						state_q <= S_MARK_RD;
					end
				end
				S_BIT_RD: begin
					state_q <= S_BIT_WR;
				end
				S_BIT_WR: begin
					// counter moves only when the bit really flips
					if (op_q == bpfa_pkg::OP_FREE && !bit_free && free_q != '1) begin
						free_q <= free_q + 1'b1;
					end else if (op_q == bpfa_pkg::OP_MARK && bit_free && free_q != '0) begin
						free_q <= free_q - 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_v_q || rsp.ready) begin
						out_st_q   <= st_q;
						out_addr_q <= res_addr_q;
						out_free_q <= free_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_st_q;
	assign rsp.page_address = out_addr_q;
	assign rsp.free_count   = out_free_q;

	// carry-in run never reaches the count, else an earlier word would have hit
	a_run_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_EV) |-> (run_q < RunW'(cnt_q)))
		else $error("carried run reached count");

	// power-on sweep writes only all-free words
	a_init_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(we && init_q) |-> (wdata == '1))
		else $error("init sweep wrote used pages");

	// no request leaves the queue until the power-on sweep is over
	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_pop)
		else $error("pop during init sweep");

	// last word of a run marks it done and goes straight to the response
	a_mark_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_WR && last_word) |=> (state_q == S_RESP))
		else $error("run mark did not finish");
endmodule
`default_nettype wire

@@ src/bitmap_page_frame_allocator.sv @@
// bitmap_page_frame_allocator: top level, config registers, front, queue, back
// depends on bpfa_pkg, bpfa_if, bpfa_front, bpfa_queue, bpfa_back
//
// channel  role    fields
// req      sink    cmd, address, count
// rsp      source  status, page_address, free_count
// cfg      sink    index, data (index 0 base_address, 1 page_total)
//
// free and mark-used read and write back one map word, reset-map sets every
// word to all free, allocate checks each 64-page word in turn and then reads
// and writes back each word of the run it marks, all through the single read
// port of the free map ram. after reset the map is swept to all free; req is
// not ready meanwhile. a two-entry queue lets requests in while one executes;
// the response register holds a result until it is taken.
`default_nettype none
module bitmap_page_frame_allocator #(
	parameter int MaxPages  = bpfa_pkg::MAX_PAGES,
	parameter int PageShift = bpfa_pkg::PAGE_SHIFT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpfa_req_if.sink   req,
	bpfa_rsp_if.source rsp,
	bpfa_cfg_if.sink   cfg
);
	localparam int IdxW    = $clog2(MaxPages);
	localparam int TotW    = $clog2(MaxPages + 1);
	localparam int QW      = bpfa_pkg::OP_W + IdxW + TotW;
	localparam int RstTot  = (MaxPages < bpfa_pkg::RESET_PAGES) ? MaxPages
	                                                             : bpfa_pkg::RESET_PAGES;
	localparam logic [bpfa_pkg::ADDR_W-1:0] PgMask =
		(bpfa_pkg::ADDR_W'(1) << PageShift) - bpfa_pkg::ADDR_W'(1);

	logic [bpfa_pkg::ADDR_W-1:0] abase_q;
	logic [TotW-1:0]             total_q;
	logic                        push;
	logic [QW-1:0]               push_data;
	logic                        pop;
	logic [QW-1:0]               pop_data;
	logic                        q_full;
	logic                        q_empty;
	logic                        back_ready;

	assign cfg.ready = 1'b1;

	// base is rounded up to a page boundary when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abase_q <= '0;
			total_q <= TotW'(RstTot);
		end else if (cfg.valid && cfg.ready) begin
			case (bpfa_pkg::reg_t'(cfg.index))
				bpfa_pkg::REG_BASE_ADDRESS: begin
					abase_q <= (cfg.data + PgMask) & ~PgMask;
				end
				bpfa_pkg::REG_PAGE_TOTAL: begin
					total_q <= (32'(cfg.data[bpfa_pkg::CNT_W-1:0]) > MaxPages)
					         ? TotW'(MaxPages) : TotW'(cfg.data[bpfa_pkg::CNT_W-1:0]);
				end
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	bpfa_front #(.MaxPages(MaxPages), .PageShift(PageShift)) u_front (
		.req       (req),
		.abase     (abase_q),
		.total     (total_q),
		.en        (back_ready),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	bpfa_queue #(.Width(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	bpfa_back #(.MaxPages(MaxPages), .PageShift(PageShift)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.abase   (abase_q),
		.total   (total_q),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.ready   (back_ready),
		.rsp     (rsp)
	);
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking testbench for bitmap_page_frame_allocator, first-fit page allocation
// depends on bpfa_pkg, bpfa_if and the allocator rtl; predicts every response in-line
`default_nettype none
module tb;
	import bpfa_pkg::*;

	typedef struct {
		cmd_t               cmd;
		logic [ADDR_W-1:0]  address;
		logic [CNT_W-1:0]   count;
	} page_req_t;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  page_address;
		logic [CNT_W-1:0]   free_count;
	} page_rsp_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpfa_req_if req ();
	bpfa_rsp_if rsp ();
	bpfa_cfg_if cfg ();

	bitmap_page_frame_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [MAX_PAGES-1:0] page_free;
	int                   pages_left;
	logic [ADDR_W-1:0]    mem_base;
	int                   pages_cfg;

	page_req_t pending_reqs[$];
	page_rsp_t expected_rsps[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	int        hold_cnt = 0;
	bit        req_taken = 1'b0;

	function automatic int managed_pages();
		return (pages_cfg > MAX_PAGES) ? MAX_PAGES : pages_cfg;
	endfunction

	function automatic logic [ADDR_W-1:0] page_base();
		logic [ADDR_W-1:0] ps;
		ps = ADDR_W'(1) << PAGE_SHIFT;
		return (mem_base + ps - 1) & ~(ps - 1);
	endfunction

	function automatic void take_page();
		if (pages_left > 0)
			pages_left--;
	endfunction

	function automatic page_rsp_t apply_page_cmd(page_req_t r);
		page_rsp_t         o;
		int                total;
		int                run;
		int                start;
		bit                found;
		logic [ADDR_W-1:0] pb;
		logic [ADDR_W-1:0] off;
		total = managed_pages();
		pb = page_base();
		o.status = ST_DONE;
		o.page_address = '0;
		found = 1'b0;
		start = 0;
		case (r.cmd)
			CMD_RESET_MAP: begin
				page_free = '1;
				pages_left = total;
			end
			CMD_ALLOC: begin
				run = 0;
				if (r.count != 0 && int'(r.count) <= total) begin
					for (int i = 0; i < total; i++) begin
						run = page_free[i] ? run + 1 : 0;
						if (run == int'(r.count)) begin
							start = i + 1 - run;
							found = 1'b1;
							break;
						end
					end
				end
				if (found) begin
					for (int i = start; i < start + int'(r.count); i++) begin
						page_free[i] = 1'b0;
						take_page();
					end
					o.page_address = pb + (ADDR_W'(start) << PAGE_SHIFT);
				end else begin
					o.status = ST_FAIL;
				end
			end
			default: begin
				off = (r.address - pb) >> PAGE_SHIFT;
				if (r.address < pb || off >= ADDR_W'(total)) begin
					o.status = ST_RANGE;
				end else if (r.cmd == CMD_FREE) begin
					if (!page_free[off]) begin
						page_free[off] = 1'b1;
						if (pages_left < 8191)
							pages_left++;
					end
				end else if (page_free[off]) begin
					page_free[off] = 1'b0;
					take_page();
				end
			end
		endcase
		o.free_count = CNT_W'(pages_left);
		return o;
	endfunction

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= CMD_RESET_MAP;
			req.address <= '0;
			req.count <= '0;
		end else if (!req.valid || req_taken) begin
			if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
				req.valid <= 1'b1;
				req.cmd <= pending_reqs[0].cmd;
				req.address <= pending_reqs[0].address;
				req.count <= pending_reqs[0].count;
				pending_reqs.pop_front();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// response ready, with the long hold-off when requested
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_cnt = 500;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= calm || $urandom_range(99) >= 19;
			end
		end
	end

	// monitor: predict on request, check on response
	always @(posedge clk) begin
		page_req_t r;
		page_rsp_t e;
		req_taken = arst_n && req.valid && req.ready;
		if (req_taken) begin
			r.cmd = cmd_t'(req.cmd);
			r.address = req.address;
			r.count = req.count;
			expected_rsps.push_back(apply_page_cmd(r));
		end
		if (arst_n && cfg.valid && cfg.ready) begin
			if (cfg.index == REG_BASE_ADDRESS)
				mem_base = cfg.data;
			else
				pages_cfg = int'(cfg.data[CNT_W-1:0]);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d addr=%h free=%0d",
						rsp.status, rsp.page_address, rsp.free_count);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status || rsp.page_address !== e.page_address ||
						rsp.free_count !== e.free_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d addr=%h free=%0d got st=%0d addr=%h free=%0d",
							e.status, e.page_address, e.free_count,
							rsp.status, rsp.page_address, rsp.free_count);
				end
			end
		end
		if (req_taken || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_req(cmd_t c, logic [ADDR_W-1:0] a, logic [CNT_W-1:0] n);
		page_req_t r;
		r.cmd = c;
		r.address = a;
		r.count = n;
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(reg_t idx, logic [ADDR_W-1:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly addresses at random offsets in pages near the managed range, plus stray ones
	task automatic random_reqs(int n);
		int                sel;
		int                total;
		logic [ADDR_W-1:0] a;
		logic [CNT_W-1:0]  k;
		for (int j = 0; j < n; j++) begin
			total = managed_pages();
			sel = $urandom_range(99);
			a = page_base() + (ADDR_W'($urandom_range(total + 3)) << PAGE_SHIFT)
				+ ADDR_W'($urandom_range((1 << PAGE_SHIFT) - 1));
			if ($urandom_range(9) == 0)
				a = {$urandom, $urandom};
			else if ($urandom_range(19) == 0)
				a = page_base() - ADDR_W'($urandom_range(1, 5000));
			k = CNT_W'($urandom_range(1, 8));
			case ($urandom_range(19))
				0: k = '0;
				1: k = CNT_W'($urandom);
				2: k = CNT_W'($urandom_range(total + 1));
				3: k = CNT_W'($urandom_range(9, 80));
				default: ;
			endcase
			if (sel < 3)
				push_req(CMD_RESET_MAP, a, k);
			else if (sel < 40)
				push_req(CMD_ALLOC, a, k);
			else if (sel < 75)
				push_req(CMD_FREE, a, k);
			else
				push_req(CMD_MARK_USED, a, k);
		end
	endtask

	initial begin
		page_free = '1;
		mem_base = '0;
		pages_cfg = RESET_PAGES;
		pages_left = RESET_PAGES;
		cfg.valid = 1'b0;
		cfg.index = REG_BASE_ADDRESS;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edge counts, double free, mark-used, range and full map
		push_req(CMD_ALLOC, '0, '0);
		push_req(CMD_ALLOC, '0, 13'd1);
		push_req(CMD_ALLOC, '0, 13'd4096);
		push_req(CMD_FREE, 48'h0, '0);
		push_req(CMD_FREE, 48'h0, '0);
		push_req(CMD_MARK_USED, 48'h5fff, '0);
		push_req(CMD_MARK_USED, 48'h5abc, '0);
		push_req(CMD_FREE, 48'h100_0000, '0);
		push_req(CMD_FREE, '1, '1);
		push_req(CMD_ALLOC, '0, '1);
		push_req(CMD_RESET_MAP, '0, '0);
		push_req(CMD_ALLOC, '0, 13'd4096);
		push_req(CMD_ALLOC, '0, 13'd1);
		push_req(CMD_FREE, 48'hfff_000, '0);
		push_req(CMD_FREE, 48'h3f_000, '0);
		push_req(CMD_FREE, 48'h40_000, '0);
		push_req(CMD_ALLOC, '0, 13'd2);
		push_req(CMD_ALLOC, '0, 13'd1);
		push_req(CMD_RESET_MAP, '0, '0);
		wait_idle();

		calm = 1'b1;
		random_reqs(150);
		wait_idle();
		calm = 1'b0;
		hold_req = 1'b1;
		random_reqs(450);
		wait_idle();

		// base near the top so returned addresses wrap; short map without reset-map
		write_reg(REG_BASE_ADDRESS, 48'hffff_ffff_8123);
		write_reg(REG_PAGE_TOTAL, 48'd100);
		random_reqs(300);
		wait_idle();

		write_reg(REG_PAGE_TOTAL, 48'd0);
		write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
		random_reqs(60);
		wait_idle();

		write_reg(REG_PAGE_TOTAL, 48'h1fff);
		write_reg(REG_BASE_ADDRESS, 48'h0);
		push_req(CMD_RESET_MAP, '0, '0);
		random_reqs(300);
		wait_idle();

		write_reg(REG_PAGE_TOTAL, 48'd64);
		write_reg(REG_BASE_ADDRESS, 48'h1001);
		random_reqs(300);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
